// File: sv/per_process_delete_rate_limiter_unit_assert.svh
// Assertion macros for the per-process delete rate limiter.
// Used by the top level only; no other dependencies.
`ifndef PER_PROCESS_DELETE_RATE_LIMITER_UNIT_ASSERT_SVH
`define PER_PROCESS_DELETE_RATE_LIMITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRDLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prdlr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRDLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prdlr assertion failed");

`endif

// File: sv/prdlr_pkg.sv
// Shared types and constants of the per-process delete rate limiter.
// No dependencies; the files that use it refer to it by scoped names.
package prdlr_pkg;

    // Process table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int PID_W    = 22;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 9;
    localparam int WIN_W    = 16;
    localparam int MAXD_W   = 8;
    localparam int STALE_W  = 20;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Operation codes.
    localparam logic OP_READ   = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ALLOW      = 2'd0;
    localparam logic [1:0] VERDICT_FAKE       = 2'd1;
    localparam logic [1:0] VERDICT_BLOCK_FLAG = 2'd2;
    localparam logic [1:0] VERDICT_BLOCK_RATE = 2'd3;

    // Register indexes.
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_MAXDEL = 2'd1;
    localparam logic [1:0] REG_STALE  = 2'd2;

    // Register reset values.
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd10;
    localparam logic [MAXD_W-1:0]  MAXDEL_RESET = 8'd2;
    localparam logic [STALE_W-1:0] STALE_RESET  = 20'd50;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic                flag;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   wstart;
        logic [PID_W-1:0]    pid;
    } t_entry;

    // One classified request.
    typedef struct packed {
        logic              op;
        logic              pid_zero;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] now;
    } t_req;

    // Configuration registers.
    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [MAXD_W-1:0]  maxdel;
        logic [STALE_W-1:0] stale;
    } t_cfg;

    // Back-end status seen by the front and the top level.
    typedef struct packed {
        logic clearing;
    } t_back_status;

    // Result beat, lowest field in the lowest bits.
    typedef struct packed {
        logic [2:0]         pad;
        logic               flagged;
        logic [COUNT_W-1:0] count;
        logic               tracked;
        logic [1:0]         verdict;
    } t_result;

endpackage

// File: sv/per_process_delete_rate_limiter_unit.sv
// Per-process delete rate limiter: configuration registers, front, back.
// Depends on prdlr_pkg, prdlr_front, prdlr_back and the assertion header.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the operation (read
//   check or delete), s_tdata the pid and the time in seconds. Each request
//   gives one result beat on the m_ stream: verdict, tracked, window count
//   and the sticky flag.
//   Three registers (window length, deletes per window, stale age) sit on
//   the APB port at byte addresses 0, 4 and 8; pready is always high.
//   The scan reads one table entry per cycle from the single table memory
//   and stops at the slot that holds the pid, or runs to the last slot; the
//   engine takes a new request only once the last one's result is registered.
//   A two-beat request queue lets the input accept while the engine works
//   and while a result waits; a stalled receiver holds the result register
//   and stops the engine before its table write, so nothing is lost.
//   After reset the table is cleared, during which s_tready stays low;
//   register writes are taken throughout.
`include "per_process_delete_rate_limiter_unit_assert.svh"

module per_process_delete_rate_limiter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields from bit 0: pid[21:0], now[53:22], zero pad[55:54]
    input  logic [prdlr_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0: verdict[1:0], tracked[2], window_count[11:3],
    // flagged[12], zero pad[15:13]
    output logic [prdlr_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [prdlr_pkg::WIN_W-1:0]   r_window;
    logic [prdlr_pkg::MAXD_W-1:0]  r_maxdel;
    logic [prdlr_pkg::STALE_W-1:0] r_stale;
    logic                          cfg_wr;
    prdlr_pkg::t_cfg               cfg;
    prdlr_pkg::t_back_status       back_status;
    prdlr_pkg::t_req               req;
    logic                          req_valid;
    logic                          req_ready;
    prdlr_pkg::t_result            res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= prdlr_pkg::WINDOW_RESET;
            r_maxdel <= prdlr_pkg::MAXDEL_RESET;
            r_stale  <= prdlr_pkg::STALE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                prdlr_pkg::REG_WINDOW: r_window <= pwdata[prdlr_pkg::WIN_W-1:0];
                prdlr_pkg::REG_MAXDEL: r_maxdel <= pwdata[prdlr_pkg::MAXD_W-1:0];
                prdlr_pkg::REG_STALE:  r_stale  <= pwdata[prdlr_pkg::STALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            prdlr_pkg::REG_WINDOW: prdata = 32'(r_window);
            prdlr_pkg::REG_MAXDEL: prdata = 32'(r_maxdel);
            prdlr_pkg::REG_STALE:  prdata = 32'(r_stale);
            default:               prdata = '0;
        endcase
    end

    assign cfg.window = r_window;
    assign cfg.maxdel = r_maxdel;
    assign cfg.stale  = r_stale;

    prdlr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .i_status    (back_status),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready),
        .o_req       (req)
    );

    prdlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .i_cfg       (cfg),
        .o_status    (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    assign res = prdlr_pkg::t_result'(m_tdata);

    // The input side stays closed while the table is cleared.
    `PRDLR_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, back_status.clearing, !s_tready)
    // No result can appear during the clear pass or right after it.
    `PRDLR_ASSERT_NXT(a_no_result_in_clear, i_clk, i_rst_n, back_status.clearing, !m_tvalid)
    // An untracked request reports an all-zero result.
    `PRDLR_ASSERT_IMP(a_untracked_zero, i_clk, i_rst_n, m_tvalid && !res.tracked, (res.verdict == prdlr_pkg::VERDICT_ALLOW) && (res.count == '0) && !res.flagged)
    // A rate-limit block always leaves the process flagged.
    `PRDLR_ASSERT_IMP(a_rate_block_flags, i_clk, i_rst_n, m_tvalid && (res.verdict == prdlr_pkg::VERDICT_BLOCK_RATE), res.flagged && res.tracked)

endmodule

// File: sv/prdlr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prdlr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/prdlr_front.sv
// Front end: accepts request beats, classifies them and queues them.
// Depends on prdlr_pkg.
module prdlr_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields from bit 0: pid[21:0], now[53:22], zero pad[55:54]
    input  logic [prdlr_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: op
    input  logic                             s_tuser,
    input  prdlr_pkg::t_back_status          i_status,
    output logic                             o_req_valid,
    input  logic                             i_req_ready,
    output prdlr_pkg::t_req                  o_req
);

    prdlr_pkg::t_req                 r_mem [prdlr_pkg::QUEUE_DEPTH];
    logic [prdlr_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [prdlr_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [prdlr_pkg::QCNT_W-1:0]    r_count;
    prdlr_pkg::t_req                 in_req;
    logic                            push;
    logic                            pop;

    // Classify the incoming beat.
    always_comb begin
        in_req.op       = s_tuser;
        in_req.pid      = s_tdata[prdlr_pkg::PID_W-1:0];
        in_req.now      = s_tdata[prdlr_pkg::PID_W +: prdlr_pkg::TIME_W];
        in_req.pid_zero = (s_tdata[prdlr_pkg::PID_W-1:0] == '0);
    end

    // No beat is taken while the table is being cleared.
    assign s_tready    = (r_count != prdlr_pkg::QCNT_W'(prdlr_pkg::QUEUE_DEPTH))
                         && !i_status.clearing;
    assign push        = s_tvalid && s_tready;
    assign o_req_valid = (r_count != '0);
    assign pop         = o_req_valid && i_req_ready;
    assign o_req       = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_req;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/prdlr_back.sv
// Back end: clears the process table after reset, scans it per request,
// updates the entry and holds the result beat. Depends on prdlr_pkg, prdlr_ram.
module prdlr_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  prdlr_pkg::t_req                  i_req,
    input  prdlr_pkg::t_cfg                  i_cfg,
    output prdlr_pkg::t_back_status          o_status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0: verdict[1:0], tracked[2], window_count[11:3],
    // flagged[12], zero pad[15:13]
    output logic [prdlr_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [prdlr_pkg::IDX_W-1:0] LAST_IDX =
        prdlr_pkg::IDX_W'(prdlr_pkg::TABLE_DEPTH - 1);

    logic [2:0]                        r_state, n_state;
    logic [prdlr_pkg::IDX_W-1:0]       r_idx, n_idx;
    prdlr_pkg::t_req                   r_req, n_req;
    logic                              r_have_free, n_have_free;
    logic [prdlr_pkg::IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                              r_found, n_found;
    logic [prdlr_pkg::IDX_W-1:0]       r_slot, n_slot;
    prdlr_pkg::t_entry                 r_ent, n_ent;
    logic                              r_out_valid, n_out_valid;
    prdlr_pkg::t_result                r_out, n_out;

    logic                              rd_en;
    logic [prdlr_pkg::IDX_W-1:0]       rd_addr;
    logic                              wr_en;
    logic [prdlr_pkg::IDX_W-1:0]       wr_addr;
    prdlr_pkg::t_entry                 wr_data;
    logic [$bits(prdlr_pkg::t_entry)-1:0] rd_raw;
    prdlr_pkg::t_entry                 rd_ent;

    logic [prdlr_pkg::TIME_W-1:0]      scan_age;
    logic                              scan_stale;
    logic [prdlr_pkg::PID_W-1:0]       scan_pid;
    logic                              scan_match;
    logic [prdlr_pkg::TIME_W-1:0]      win_age;
    logic [prdlr_pkg::COUNT_W-1:0]     inc_count;
    prdlr_pkg::t_entry                 upd_ent;
    logic [1:0]                        upd_verdict;
    logic                              out_free;

    prdlr_ram #(
        .WIDTH ($bits(prdlr_pkg::t_entry)),
        .DEPTH (prdlr_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_ent = prdlr_pkg::t_entry'(rd_raw);

    // Per-entry scan checks: staleness, then pid match on the cleaned entry.
    always_comb begin
        scan_age   = r_req.now - rd_ent.wstart;
        scan_stale = (rd_ent.pid != '0) &&
                     (scan_age > prdlr_pkg::TIME_W'(i_cfg.stale));
        scan_pid   = scan_stale ? '0 : rd_ent.pid;
        scan_match = !r_req.pid_zero && (scan_pid == r_req.pid);
    end

    // Operation applied to the resolved entry.
    always_comb begin
        upd_ent     = r_ent;
        upd_verdict = prdlr_pkg::VERDICT_ALLOW;
        inc_count   = (r_ent.count < prdlr_pkg::COUNT_MAX) ?
                      r_ent.count + 1'b1 : r_ent.count;
        if (r_req.op == prdlr_pkg::OP_READ) begin
            upd_verdict = r_ent.flag ? prdlr_pkg::VERDICT_FAKE : prdlr_pkg::VERDICT_ALLOW;
        end else if (r_ent.flag) begin
            upd_verdict = prdlr_pkg::VERDICT_BLOCK_FLAG;
        end else begin
            upd_ent.count = inc_count;
            if (inc_count > prdlr_pkg::COUNT_W'(i_cfg.maxdel)) begin
                upd_ent.flag = 1'b1;
                upd_verdict  = prdlr_pkg::VERDICT_BLOCK_RATE;
            end
        end
    end

    assign win_age  = r_req.now - r_ent.wstart;
    assign out_free = !r_out_valid || m_tready;

    // Sequencer: clear pass, scan, window fix-up, update and result.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_req       = r_req;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_found     = r_found;
        n_slot      = r_slot;
        n_ent       = r_ent;
        n_out_valid = (r_out_valid && m_tready) ? 1'b0 : r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req       = i_req;
                    n_idx       = '0;
                    n_have_free = 1'b0;
                    n_found     = 1'b0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Stale entries are freed as the scan passes them.
                wr_en = scan_stale;
                if (scan_match) begin
                    n_found = 1'b1;
                    n_slot  = r_idx;
                    n_ent   = rd_ent;
                    n_state = ST_FIX;
                end else begin
                    if ((scan_pid == '0) && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_free_idx  = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FIX;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end
            ST_FIX: begin
                if (r_found) begin
                    if (win_age >= prdlr_pkg::TIME_W'(i_cfg.window)) begin
                        n_ent.wstart = r_req.now;
                        n_ent.count  = '0;
                    end
                end else if (!r_req.pid_zero && r_have_free) begin
                    n_found      = 1'b1;
                    n_slot       = r_free_idx;
                    n_ent.pid    = r_req.pid;
                    n_ent.wstart = r_req.now;
                    n_ent.count  = '0;
                    n_ent.flag   = 1'b0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_found) begin
                        wr_en         = 1'b1;
                        wr_addr       = r_slot;
                        wr_data       = upd_ent;
                        n_out.verdict = upd_verdict;
                        n_out.tracked = 1'b1;
                        n_out.count   = upd_ent.count;
                        n_out.flagged = upd_ent.flag;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_have_free <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_have_free <= n_have_free;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_free_idx <= n_free_idx;
        r_slot     <= n_slot;
        r_ent      <= n_ent;
        r_out      <= n_out;
    end

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign m_tvalid          = r_out_valid;
    assign m_tdata           = r_out;

endmodule
